// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/macp_pkg.sv =====
// ----------------------------------------------------------------------------
// macp_pkg
// types, constants and helpers of the mac address text parser
// ----------------------------------------------------------------------------
package macp_pkg;

  localparam int unsigned AddressBytes = 6;
  localparam int unsigned AddrWidth    = 48;

  localparam logic [2:0] LastPair  = 3'(AddressBytes);
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharColon = 8'h3A;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  typedef enum logic [2:0] {
    PhLead  = 3'd0,
    PhHi    = 3'd1,
    PhLo    = 3'd2,
    PhSep   = 3'd3,
    PhTrail = 3'd4,
    PhErr   = 3'd5
  } phase_e;

  typedef struct packed {
    phase_e                 phase;
    logic [2:0]             pair_index;
    logic [3:0]             high_nibble;
    logic [AddrWidth-1:0]   acc;
  } parse_state_t;

  typedef struct packed {
    logic                 valid;
    logic                 status;
    logic [AddrWidth-1:0] mac;
  } parse_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  localparam parse_state_t StateReset = '{
    phase:       PhLead,
    pair_index:  3'd0,
    high_nibble: 4'd0,
    acc:         '0
  };

  function automatic hex_digit_t hex_digit(input logic [7:0] ch);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      d.value = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      d.value = 4'(ch - 8'h61 + 8'd10);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      d.value = 4'(ch - 8'h41 + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/mac_address_text_parser.sv =====
// ----------------------------------------------------------------------------
// mac_address_text_parser
// parses AA:BB:CC:DD:EE:FF text, one character per transaction, into a
// 48-bit address and a status, one result per NUL-terminated string
// ----------------------------------------------------------------------------
//   channel   direction  signals                                   payload
//   in        input      in_valid_i / in_ready_o                   char_byte_i
//   out       output     out_valid_o / out_ready_i                 parse_status_o, mac_address_o
//
// one character per cycle unless a NUL stalls on the output; each character is held in the
// input register, the parser state updates as it leaves, and a NUL loads the result register
// reset puts the parser in its leading-space phase with empty input/output
// registers; only a NUL waits on a full output register that is not taken,
// other characters keep flowing while a result is pending
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mac_address_text_parser import macp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 parse_status_o,
  output logic [AddrWidth-1:0] mac_address_o
);

  logic                 in_valid_q;
  logic [7:0]           char_q;
  parse_state_t         state_q;
  parse_state_t         state_d;
  parse_result_t        result;
  logic                 out_valid_q;
  logic                 out_valid_d;
  logic                 status_q;
  logic [AddrWidth-1:0] mac_q;
  logic                 fire;

  macp_step u_step (
    .state_i  (state_q),
    .char_i   (char_q),
    .state_o  (state_d),
    .result_o (result)
  );

  assign fire        = in_valid_q && (!result.valid || !out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_d = (fire && result.valid) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= StateReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_byte_i;
    end
    if (fire && result.valid) begin
      status_q <= result.status;
      mac_q    <= result.mac;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign parse_status_o = status_q;
  assign mac_address_o  = mac_q;

  `ASSERT_IMPLY(a_bad_zero, clk_i, rst_ni, out_valid_o && parse_status_o == StatusBad, mac_address_o == '0)
  `ASSERT_NEXT(a_nul_result, clk_i, rst_ni, fire && char_q == CharNul, out_valid_q)
  `ASSERT_NEXT(a_nul_restart, clk_i, rst_ni, fire && char_q == CharNul, state_q.phase == PhLead && state_q.pair_index == 3'd0)
  `ASSERT_NEXT(a_stage_hold, clk_i, rst_ni, in_valid_q && !fire, in_valid_q && $stable(char_q))

endmodule

// ===== rtl/core/macp_step.sv =====
// ----------------------------------------------------------------------------
// macp_step
// next-state and result logic for one character of the address string
// ----------------------------------------------------------------------------
module macp_step import macp_pkg::*; (
  input  parse_state_t  state_i,
  input  logic [7:0]    char_i,
  output parse_state_t  state_o,
  output parse_result_t result_o
);

  hex_digit_t digit;
  logic [2:0] pair_next;

  assign digit     = hex_digit(char_i);
  assign pair_next = state_i.pair_index + 3'd1;

  always_comb begin
    state_o         = state_i;
    result_o.valid  = 1'b0;
    result_o.status = StatusOk;
    result_o.mac    = '0;
    if (char_i == CharNul) begin
      result_o.valid = 1'b1;
      if (state_i.phase == PhTrail) begin
        result_o.status = StatusOk;
        result_o.mac    = state_i.acc;
      end else begin
        result_o.status = StatusBad;
      end
      state_o = StateReset;
    end else begin
      unique case (state_i.phase)
        PhLead, PhHi: begin
          if (!(state_i.phase == PhLead && char_i == CharSpace)) begin
            if (!digit.ok) begin
              state_o.phase = PhErr;
            end else begin
              state_o.high_nibble = digit.value;
              state_o.phase       = PhLo;
            end
          end
        end
        PhLo: begin
          if (!digit.ok) begin
            state_o.phase = PhErr;
          end else begin
            state_o.acc        = {state_i.acc[AddrWidth-9:0], state_i.high_nibble, digit.value};
            state_o.pair_index = pair_next;
            if (pair_next == LastPair || pair_next == 3'd0) begin
              state_o.phase = PhTrail;
            end else begin
              state_o.phase = PhSep;
            end
          end
        end
        PhSep: begin
          state_o.phase = (char_i == CharColon) ? PhHi : PhErr;
        end
        PhTrail: begin
          if (char_i != CharSpace) begin
            state_o.phase = PhErr;
          end
        end
        default: begin
          state_o.phase = PhErr;
        end
      endcase
    end
  end

endmodule
